// ===== hdl/lsef_pkg.sv =====
// Shared types, constants and header byte selection for the log stream Ethernet framer.
`timescale 1ns / 1ps

package lsef_pkg;

  // Frame size bound and header layout
  localparam int unsigned MaxTxBytes  = 1400;
  localparam int unsigned HdrBytes    = 18;
  localparam int unsigned LimitCap    = MaxTxBytes - HdrBytes;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned MacW        = 48;
  localparam int unsigned EtherTypeW  = 16;
  localparam int unsigned CountW      = 11;
  localparam int unsigned HdrIdxW     = $clog2(HdrBytes + 1);
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = MacW;

  // Reset values of the configuration registers
  localparam logic [MacW-1:0]       SrcMacReset    = 48'h025A6D627369;
  localparam logic [EtherTypeW-1:0] EtherTypeReset = 16'h88B5;
  localparam logic [CountW-1:0]     MaxPayloadReset = CountW'(1382);

  // Fixed header bytes after the ethertype
  localparam logic [ByteW-1:0] MagicHi  = 8'h5A;
  localparam logic [ByteW-1:0] MagicLo  = 8'h62;
  localparam logic [ByteW-1:0] Version  = 8'h01;

  // Header byte positions
  localparam logic [HdrIdxW-1:0] IdxSrcMac    = HdrIdxW'(6);
  localparam logic [HdrIdxW-1:0] IdxEtherHi   = HdrIdxW'(12);
  localparam logic [HdrIdxW-1:0] IdxEtherLo   = HdrIdxW'(13);
  localparam logic [HdrIdxW-1:0] IdxMagicHi   = HdrIdxW'(14);
  localparam logic [HdrIdxW-1:0] IdxMagicLo   = HdrIdxW'(15);
  localparam logic [HdrIdxW-1:0] IdxVersion   = HdrIdxW'(16);
  localparam logic [HdrIdxW-1:0] IdxType      = HdrIdxW'(17);
  localparam logic [HdrIdxW-1:0] IdxHdrEnd    = HdrIdxW'(HdrBytes);

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable     = 3'd0,
    CfgDstMac     = 3'd1,
    CfgSrcMac     = 3'd2,
    CfgEtherType  = 3'd3,
    CfgMaxPayload = 3'd4
  } cfg_idx_e;

  // Pick byte i of a MAC, first transmitted byte at bits 47..40
  function automatic logic [ByteW-1:0] mac_byte(input logic [MacW-1:0] mac,
                                                input logic [2:0] idx);
    logic [MacW-1:0] shifted;
    shifted = mac << (ByteW * idx);
    return shifted[MacW-1 -: ByteW];
  endfunction

  // Select one header byte by position
  function automatic logic [ByteW-1:0] hdr_byte(input logic [HdrIdxW-1:0] idx,
                                                input logic [MacW-1:0] dst,
                                                input logic [MacW-1:0] src,
                                                input logic [EtherTypeW-1:0] etype,
                                                input logic [ByteW-1:0] mtype);
    logic [ByteW-1:0] b;
    logic [HdrIdxW-1:0] src_off;
    src_off = idx - IdxSrcMac;
    b = '0;
    if (idx < IdxSrcMac) begin
      b = mac_byte(dst, idx[2:0]);
    end else if (idx < IdxEtherHi) begin
      b = mac_byte(src, src_off[2:0]);
    end else begin
      case (idx)
        IdxEtherHi: b = etype[EtherTypeW-1 -: ByteW];
        IdxEtherLo: b = etype[ByteW-1:0];
        IdxMagicHi: b = MagicHi;
        IdxMagicLo: b = MagicLo;
        IdxVersion: b = Version;
        IdxType:    b = mtype;
        default:    b = '0;
      endcase
    end
    return b;
  endfunction

endpackage

// ===== hdl/log_stream_ethernet_framer.sv =====
// Top level of the log stream Ethernet framer: item register, header sequencing, output register.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid_i / in_stall_o | payload_byte_i, msg_type_i, end_of_message_i
// out      | output    | out_valid_o / out_stall_i | frame_byte_o, end_of_frame_o, last_of_run_o
// cfg      | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A byte that continues an open frame is sent with no header before it; a byte that opens a frame
// follows the header, the header counter stepping one header byte per cycle unless stalled.
// The held byte and the output register are separate, so the next byte is taken
// in the cycle its predecessor leaves the held register.
// Reset clears control state and loads the configuration reset values.
// A stall on the output holds the output register and, through it, the input.
module log_stream_ethernet_framer
  import lsef_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ByteW-1:0]    payload_byte_i,
  input  logic [ByteW-1:0]    msg_type_i,
  input  logic                end_of_message_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [ByteW-1:0]    frame_byte_o,
  output logic                end_of_frame_o,
  output logic                last_of_run_o,

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic                  enable_q;
  logic [MacW-1:0]       dst_mac_q;
  logic [MacW-1:0]       src_mac_q;
  logic [EtherTypeW-1:0] ether_type_q;
  logic [CountW-1:0]     max_payload_q;

  // Frame state
  logic                  in_frame_q, in_frame_d;
  logic [CountW-1:0]     payload_count_q, payload_count_d;
  logic [HdrIdxW-1:0]    hdr_idx_q, hdr_idx_d;

  // Held input item
  logic                  item_valid_q, item_valid_d;
  logic [ByteW-1:0]      item_byte_q;
  logic [ByteW-1:0]      item_type_q;
  logic                  item_eom_q;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [ByteW-1:0]      out_byte_q;
  logic                  out_eof_q;
  logic                  out_last_q;

  logic                  out_free;
  logic                  advance;
  logic                  is_hdr;
  logic                  item_done;
  logic                  in_accept;
  logic                  item_load;
  logic [CountW-1:0]     limit;
  logic [CountW-1:0]     count_next;
  logic                  frame_ends;
  logic [ByteW-1:0]      emit_byte;

  // Take configuration writes at any time
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      dst_mac_q     <= '0;
      src_mac_q     <= SrcMacReset;
      ether_type_q  <= EtherTypeReset;
      max_payload_q <= MaxPayloadReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgEnable:     enable_q      <= cfg_data_i[0];
        CfgDstMac:     dst_mac_q     <= cfg_data_i[MacW-1:0];
        CfgSrcMac:     src_mac_q     <= cfg_data_i[MacW-1:0];
        CfgEtherType:  ether_type_q  <= cfg_data_i[EtherTypeW-1:0];
        CfgMaxPayload: max_payload_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the payload limit to at least one and to what fits in the largest frame
  always_comb begin
    limit = max_payload_q;
    if (max_payload_q == '0) begin
      limit = CountW'(1);
    end else if (max_payload_q > CountW'(LimitCap)) begin
      limit = CountW'(LimitCap);
    end
  end

  // Step through header bytes, then send the payload byte
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = item_valid_q && out_free;
  assign is_hdr     = !in_frame_q && (hdr_idx_q != IdxHdrEnd);
  assign item_done  = advance && !is_hdr;
  assign count_next = payload_count_q + CountW'(1);
  assign frame_ends = item_eom_q || (count_next >= limit);
  assign emit_byte  = is_hdr ? hdr_byte(hdr_idx_q, dst_mac_q, src_mac_q, ether_type_q,
                                        item_type_q)
                             : item_byte_q;

  // Accept while the held item is empty or leaves this cycle; drop when disabled
  assign in_stall_o = item_valid_q && !item_done;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign item_load  = in_accept && enable_q;

  always_comb begin
    in_frame_d      = in_frame_q;
    payload_count_d = payload_count_q;
    hdr_idx_d       = hdr_idx_q;
    if (advance) begin
      if (is_hdr) begin
        hdr_idx_d = hdr_idx_q + HdrIdxW'(1);
      end else begin
        hdr_idx_d       = '0;
        in_frame_d      = !frame_ends;
        payload_count_d = frame_ends ? '0 : count_next;
      end
    end
  end

  always_comb begin
    if (item_load) begin
      item_valid_d = 1'b1;
    end else if (item_done) begin
      item_valid_d = 1'b0;
    end else begin
      item_valid_d = item_valid_q;
    end
  end

  assign out_valid_d = out_free ? advance : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q      <= 1'b0;
      payload_count_q <= '0;
      hdr_idx_q       <= '0;
      item_valid_q    <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      in_frame_q      <= in_frame_d;
      payload_count_q <= payload_count_d;
      hdr_idx_q       <= hdr_idx_d;
      item_valid_q    <= item_valid_d;
      out_valid_q     <= out_valid_d;
    end
  end

  // Hold the item payload
  always_ff @(posedge clk_i) begin
    if (item_load) begin
      item_byte_q <= payload_byte_i;
      item_type_q <= msg_type_i;
      item_eom_q  <= end_of_message_i;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= emit_byte;
      out_eof_q  <= !is_hdr && frame_ends;
      out_last_q <= !is_hdr;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = out_byte_q;
  assign end_of_frame_o = out_eof_q;
  assign last_of_run_o  = out_last_q;

  // Header counter never runs past the header
  assert property (@(posedge clk_i) disable iff (!rst_ni) hdr_idx_q <= IdxHdrEnd)
    else $error("header counter out of range");

  // An open frame has no header in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_frame_q |-> hdr_idx_q == '0)
    else $error("header counter active inside an open frame");

  // An open frame has carried at least one payload byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_frame_q |-> payload_count_q != '0)
    else $error("open frame with zero payload count");

  // A header byte never closes a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && !last_of_run_o) |-> !end_of_frame_o)
    else $error("frame closed on a header byte");

endmodule

// ===== bench/log_stream_ethernet_framer_tb.sv =====
// Self-checking testbench for the log stream Ethernet framer: header insertion, splitting, drop.
`timescale 1ns / 1ps

module log_stream_ethernet_framer_tb;
  import lsef_pkg::*;

  // One byte on the wire as the framer should emit it
  typedef struct packed {
    logic [ByteW-1:0] frame_byte;
    logic             end_of_frame;
    logic             last_of_run;
  } wire_byte_t;

  // Tracks framer state and configuration, and the wire bytes still owed
  class frame_scoreboard;
    wire_byte_t             frame_q[$];
    int unsigned            errors;
    bit                     enable;
    logic [MacW-1:0]        dst_mac;
    logic [MacW-1:0]        src_mac;
    logic [EtherTypeW-1:0]  ether_type;
    logic [CountW-1:0]      max_payload;
    bit                     in_frame;
    logic [CountW-1:0]      payload_count;

    function new();
      errors        = 0;
      enable        = 1'b0;
      dst_mac       = '0;
      src_mac       = SrcMacReset;
      ether_type    = EtherTypeReset;
      max_payload   = MaxPayloadReset;
      in_frame      = 1'b0;
      payload_count = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgEnable:     enable      = data[0];
        CfgDstMac:     dst_mac     = data[MacW-1:0];
        CfgSrcMac:     src_mac     = data[MacW-1:0];
        CfgEtherType:  ether_type  = data[EtherTypeW-1:0];
        CfgMaxPayload: max_payload = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    // Work out the wire bytes caused by one accepted message byte
    function void note_byte(logic [ByteW-1:0] pb, logic [ByteW-1:0] ty, logic eom);
      logic [CountW-1:0] limit;
      logic [ByteW-1:0]  hdr [HdrBytes];
      bit                closes;
      // drop input while disabled; an open frame stays open
      if (!enable) return;
      limit = (max_payload == '0) ? CountW'(1) : max_payload;
      if (limit > CountW'(LimitCap)) limit = CountW'(LimitCap);
      if (!in_frame) begin
        for (int i = 0; i < 6; i++) begin
          hdr[i]     = dst_mac[MacW-1-8*i -: 8];
          hdr[6 + i] = src_mac[MacW-1-8*i -: 8];
        end
        hdr[12] = ether_type[15:8];
        hdr[13] = ether_type[7:0];
        hdr[14] = MagicHi;
        hdr[15] = MagicLo;
        hdr[16] = Version;
        hdr[17] = ty;
        for (int i = 0; i < HdrBytes; i++) frame_q.push_back('{hdr[i], 1'b0, 1'b0});
        in_frame      = 1'b1;
        payload_count = '0;
      end
      payload_count = payload_count + 1'b1;
      closes = eom || (payload_count >= limit);
      frame_q.push_back('{pb, closes, 1'b1});
      if (closes) begin
        in_frame      = 1'b0;
        payload_count = '0;
      end
    endfunction

    // Compare one accepted output transaction with the oldest expectation
    function void check_wire_byte(logic [ByteW-1:0] fb, logic eof, logic last);
      wire_byte_t exp_b;
      if (frame_q.size() == 0) begin
        $error("frame_byte: no transaction expected, actual %0h", fb);
        errors++;
        return;
      end
      exp_b = frame_q.pop_front();
      if (fb !== exp_b.frame_byte) begin
        $error("frame_byte: expected %0h, actual %0h", exp_b.frame_byte, fb);
        errors++;
      end
      if (eof !== exp_b.end_of_frame) begin
        $error("end_of_frame: expected %0b, actual %0b", exp_b.end_of_frame, eof);
        errors++;
      end
      if (last !== exp_b.last_of_run) begin
        $error("last_of_run: expected %0b, actual %0b", exp_b.last_of_run, last);
        errors++;
      end
    endfunction

    function int pending();
      return frame_q.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ByteW-1:0]    payload_byte_i;
  logic [ByteW-1:0]    msg_type_i;
  logic                end_of_message_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [ByteW-1:0]    frame_byte_o;
  logic                end_of_frame_o;
  logic                last_of_run_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  frame_scoreboard sb = new;
  bit              idle_on = 1'b1;
  int unsigned     stall_left;
  int unsigned     bytes_sent;

  log_stream_ethernet_framer i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .payload_byte_i   (payload_byte_i),
    .msg_type_i       (msg_type_i),
    .end_of_message_i (end_of_message_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .frame_byte_o     (frame_byte_o),
    .end_of_frame_o   (end_of_frame_o),
    .last_of_run_o    (last_of_run_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // Stall the output in random bursts
  always @(posedge clk_i) begin
    if (!rst_ni || !idle_on) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 9);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check every accepted output transaction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_wire_byte(frame_byte_o, end_of_frame_o, last_of_run_o);
    end
  end

  // Offer one message byte, hold it until accepted, then maybe idle
  task automatic send(logic [ByteW-1:0] pb, logic [ByteW-1:0] ty, logic eom);
    in_valid_i       <= 1'b1;
    payload_byte_i   <= pb;
    msg_type_i       <= ty;
    end_of_message_i <= eom;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_byte(pb, ty, eom);
    if (sb.enable) bytes_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed byte has left, plus settling time
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [MacW-1:0] rand_mac();
    return MacW'({$urandom(), $urandom()});
  endfunction

  function automatic logic [CountW-1:0] rand_limit();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return CountW'($urandom());
      3:       return CountW'(LimitCap);
      4:       return CountW'(LimitCap + 1);
      default: return CountW'($urandom_range(1, 12));
    endcase
  endfunction

  initial begin
    int unsigned      len;
    logic [ByteW-1:0] ty;
    logic             eom;

    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    payload_byte_i   <= '0;
    msg_type_i       <= '0;
    end_of_message_i <= 1'b0;
    cfg_valid_i      <= 1'b0;
    cfg_index_i      <= CfgEnable;
    cfg_data_i       <= '0;
    bytes_sent       = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Disabled after reset: bytes are dropped
    send(8'h00, 8'h01, 1'b1);
    send(8'hFF, 8'h02, 1'b0);
    drain();

    // Extreme addresses, limit of zero raised to one
    write_reg(CfgDstMac, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgSrcMac, '0);
    write_reg(CfgEtherType, CfgDataW'(16'hFFFF));
    write_reg(CfgMaxPayload, '0);
    write_reg(CfgEnable, CfgDataW'(1'b1));
    send(8'h00, 8'h00, 1'b0);
    send(8'hFF, 8'hFF, 1'b0);
    send(8'h5A, 8'h01, 1'b1);
    drain();

    // Over-range limit capped; type change inside a frame is ignored
    write_reg(CfgDstMac, '0);
    write_reg(CfgSrcMac, 48'hFFFF_FFFF_FFFF);
    write_reg(CfgEtherType, '0);
    write_reg(CfgMaxPayload, '1);
    send(8'h11, 8'h01, 1'b0);
    send(8'h22, 8'h02, 1'b0);
    send(8'h33, 8'hFF, 1'b1);
    send(8'h44, 8'h02, 1'b0);
    send(8'h55, 8'h02, 1'b0);
    drain();

    // Disable with a frame open, then resume it
    write_reg(CfgEnable, CfgDataW'(1'b0));
    send(8'h66, 8'h01, 1'b1);
    drain();
    write_reg(CfgEnable, CfgDataW'(1'b1));

    // Lower the limit to the count of the open frame: next byte closes it
    write_reg(CfgMaxPayload, CfgDataW'(2));
    send(8'h77, 8'h01, 1'b0);
    send(8'h88, 8'h02, 1'b0);
    send(8'h99, 8'h02, 1'b1);
    drain();

    // Random phases, each with fresh settings
    while (bytes_sent < 420) begin
      if (bytes_sent >= 360) idle_on = 1'b0;
      drain();
      write_reg(CfgDstMac, rand_mac());
      write_reg(CfgSrcMac, rand_mac());
      write_reg(CfgEtherType, CfgDataW'($urandom_range(0, 16'hFFFF)));
      write_reg(CfgMaxPayload, CfgDataW'(rand_limit()));
      if (bytes_sent < 360 && $urandom_range(0, 7) == 0) begin
        // drop phase: a few bytes that must vanish
        write_reg(CfgEnable, CfgDataW'(1'b0));
        repeat (4) send(8'($urandom()), 8'($urandom()), 1'($urandom()));
        continue;
      end
      write_reg(CfgEnable, CfgDataW'(1'b1));
      repeat ($urandom_range(4, 8)) begin
        len = $urandom_range(1, 16);
        case ($urandom_range(0, 3))
          0:       ty = 8'($urandom());
          1:       ty = 8'h01;
          default: ty = 8'h02;
        endcase
        for (int k = 0; k < len; k++) begin
          eom = (k == len - 1);
          // occasionally break the message framing
          if ($urandom_range(0, 9) == 0) eom = 1'($urandom());
          send(8'($urandom()), ty, eom);
        end
        // let the output catch up entirely now and then
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("log_stream_ethernet_framer: match");
    end else begin
      $display("log_stream_ethernet_framer: mismatch");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes
  initial begin
    #2_000_000;
    $display("log_stream_ethernet_framer: mismatch");
    $finish;
  end

endmodule
